@@ rtl/core/bdt_pkg.sv @@
// ----------------------------------------------------------------------------
// bdt_pkg
// Shared types and character codes for the brace depth tracker.
// ----------------------------------------------------------------------------
package bdt_pkg;

  localparam logic [7:0] CH_STAR      = 8'h2A;  // '*'
  localparam logic [7:0] CH_SLASH     = 8'h2F;  // '/'
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;  // '\'
  localparam logic [7:0] CH_DQUOTE    = 8'h22;  // '"'
  localparam logic [7:0] CH_SQUOTE    = 8'h27;  // '''
  localparam logic [7:0] CH_LBRACE    = 8'h7B;  // '{'
  localparam logic [7:0] CH_RBRACE    = 8'h7D;  // '}'

  localparam int unsigned OUT_DEPTH_W = 16;

  // Lexer mode and lookahead flags.
  typedef struct packed {
    logic block_cmt;
    logic str_lit;
    logic chr_lit;
    logic star_pend;
    logic slash_pend;
    logic skip_next;
    logic line_cmt;
  } bdt_flags_t;

  localparam bdt_flags_t FLAGS_CLEAR = '0;

endpackage

@@ rtl/core/bdt_step.sv @@
// ----------------------------------------------------------------------------
// bdt_step
// Next-state logic for one character: comment, literal and escape tracking
// plus saturating brace depth update.
// ----------------------------------------------------------------------------
module bdt_step #(
  parameter int unsigned DEPTH_BITS = 16
) (
  input  logic [7:0]             char_code,
  input  logic                   line_end,
  input  logic                   restart,
  input  logic [DEPTH_BITS-1:0]  depth_cur,
  input  bdt_pkg::bdt_flags_t    flags_cur,
  output logic [DEPTH_BITS-1:0]  depth_new,
  output bdt_pkg::bdt_flags_t    flags_new
);
  import bdt_pkg::*;

  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
  localparam logic [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
  localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = {{(DEPTH_BITS-1){1'b0}}, 1'b1};

  bdt_flags_t            f;
  logic [DEPTH_BITS-1:0] d;
  logic                  plain;
  logic                  free_text;

  always_comb begin
    f = restart ? FLAGS_CLEAR : flags_cur;
    d = restart ? '0 : depth_cur;
    plain = 1'b0;
    free_text = 1'b0;

    if (f.skip_next) begin
      f.skip_next = 1'b0;
    end else if (f.line_cmt) begin
      if (line_end) f.line_cmt = 1'b0;
    end else if (f.block_cmt) begin
      if (f.star_pend && char_code == CH_SLASH) begin
        f.block_cmt = 1'b0;
        f.star_pend = 1'b0;
      end else begin
        f.star_pend = (char_code == CH_STAR) && !line_end;
      end
    end else if (f.slash_pend) begin
      f.slash_pend = 1'b0;
      if (char_code == CH_STAR) begin
        f.block_cmt = 1'b1;
      end else if (char_code == CH_SLASH) begin
        if (!line_end) f.line_cmt = 1'b1;
      end else begin
        plain = 1'b1;
      end
    end else begin
      plain = 1'b1;
    end

    if (plain) begin
      free_text = !f.str_lit && !f.chr_lit;
      if (free_text && char_code == CH_SLASH) begin
        if (!line_end) f.slash_pend = 1'b1;
      end else if (char_code == CH_BACKSLASH) begin
        if (!line_end) f.skip_next = 1'b1;
      end else begin
        if (!f.chr_lit && char_code == CH_DQUOTE) begin
          f.str_lit = !f.str_lit;
        end else if (!f.str_lit && char_code == CH_SQUOTE) begin
          f.chr_lit = !f.chr_lit;
        end
        if (!f.str_lit && !f.chr_lit) begin
          if (char_code == CH_LBRACE && d != DEPTH_MAX) begin
            d = d + DEPTH_ONE;
          end else if (char_code == CH_RBRACE && d != DEPTH_MIN) begin
            d = d - DEPTH_ONE;
          end
        end
      end
    end

    depth_new = d;
    flags_new = f;
  end

endmodule

@@ rtl/core/brace_depth_tracker_core.sv @@
// A result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one character per cycle unless out_ready stalls a held result;
// the state update is combinational flag logic plus one depth increment/decrement.
// in_ready stays high while the result register is empty or being drained.
// Reset (rst_n low, synchronous) clears depth, all mode flags and the
// result valid; restart on a beat clears depth and mode flags for that character.
// ----------------------------------------------------------------------------
// brace_depth_tracker_core
// Comment- and literal-aware brace depth counter, one source byte per beat.
// ----------------------------------------------------------------------------
module brace_depth_tracker_core #(
  parameter int unsigned DEPTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_line_end,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] out_brace_depth,
  output logic        out_inside_block_comment,
  output logic        out_inside_string,
  output logic        out_inside_char_literal
);
  import bdt_pkg::*;

  logic [DEPTH_BITS-1:0]  depth_r;
  logic [DEPTH_BITS-1:0]  depth_nxt;
  bdt_flags_t             flags_r;
  bdt_flags_t             flags_nxt;
  logic                   out_valid_r;
  logic [15:0]            res_depth_r;
  logic [15:0]            res_depth_nxt;
  logic                   res_blk_r;
  logic                   res_str_r;
  logic                   res_chr_r;
  logic                   in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  bdt_step #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_step (
    .char_code (in_char_code),
    .line_end  (in_line_end),
    .restart   (in_restart),
    .depth_cur (depth_r),
    .flags_cur (flags_r),
    .depth_new (depth_nxt),
    .flags_new (flags_nxt)
  );

  // Report the low 16 bits, sign-extended when the counter is narrower.
  generate
    if (DEPTH_BITS >= OUT_DEPTH_W) begin : g_trunc
      assign res_depth_nxt = depth_nxt[OUT_DEPTH_W-1:0];
    end else begin : g_sext
      assign res_depth_nxt = {{(OUT_DEPTH_W-DEPTH_BITS){depth_nxt[DEPTH_BITS-1]}},
                              depth_nxt};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      flags_r     <= FLAGS_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        depth_r <= depth_nxt;
        flags_r <= flags_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_depth_r <= res_depth_nxt;
      res_blk_r   <= flags_nxt.block_cmt;
      res_str_r   <= flags_nxt.str_lit;
      res_chr_r   <= flags_nxt.chr_lit;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_brace_depth          = res_depth_r;
  assign out_inside_block_comment = res_blk_r;
  assign out_inside_string        = res_str_r;
  assign out_inside_char_literal  = res_chr_r;

endmodule

@@ rtl/core/bdt_checker.sv @@
// ----------------------------------------------------------------------------
// bdt_checker
// Port-level checks for brace_depth_tracker_core, attached by bind.
// ----------------------------------------------------------------------------
module bdt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_brace_depth,
  input logic        out_inside_block_comment,
  input logic        out_inside_string,
  input logic        out_inside_char_literal
);

  // Result register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // Every accepted beat yields a result on the next cycle.
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted beat produced no result");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_brace_depth)
      && $stable(out_inside_block_comment) && $stable(out_inside_string)
      && $stable(out_inside_char_literal)))
    else $error("stalled result changed");

  // String and char literal modes are mutually exclusive.
  a_lit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_inside_string && out_inside_char_literal))
    else $error("string and char literal both set");

  // A block comment can only open from free text.
  a_cmt_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_inside_block_comment)
      |-> (!out_inside_string && !out_inside_char_literal))
    else $error("block comment overlaps a literal");

endmodule

bind brace_depth_tracker_core bdt_checker u_bdt_checker (
  .clk                      (clk),
  .rst_n                    (rst_n),
  .in_valid                 (in_valid),
  .in_ready                 (in_ready),
  .out_valid                (out_valid),
  .out_ready                (out_ready),
  .out_brace_depth          (out_brace_depth),
  .out_inside_block_comment (out_inside_block_comment),
  .out_inside_string        (out_inside_string),
  .out_inside_char_literal  (out_inside_char_literal)
);

@@ test/tb_brace_depth_tracker_core.sv @@
// ----------------------------------------------------------------------------
// tb_brace_depth_tracker_core
// Self-checking bench for the brace depth tracker core. It streams C-like
// text through the byte channel under several handshake pressure mixes,
// predicts depth and lexer mode after every character, and checks each
// result beat in order.
// ----------------------------------------------------------------------------
module tb_brace_depth_tracker_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bdt_pkg::*;

  localparam int unsigned DEPTH_BITS = 16;

  typedef struct packed {
    logic signed [15:0] depth;
    logic               in_block;
    logic               in_str;
    logic               in_chr;
  } lex_view_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_char_code = 8'h00;
  logic in_line_end = 1'b0;
  logic in_restart = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_brace_depth;
  logic out_inside_block_comment;
  logic out_inside_string;
  logic out_inside_char_literal;

  // predicted lexer state
  bdt_flags_t                   lex_state = FLAGS_CLEAR;
  logic signed [DEPTH_BITS-1:0] brace_level = '0;
  lex_view_t                    expected_views[$];

  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned chars_sent = 0;
  int unsigned views_checked = 0;
  int unsigned mismatch_count = 0;

  brace_depth_tracker_core #(
    .DEPTH_BITS(DEPTH_BITS)
  ) i_dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .in_char_code             (in_char_code),
    .in_line_end              (in_line_end),
    .in_restart               (in_restart),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_brace_depth          (out_brace_depth),
    .out_inside_block_comment (out_inside_block_comment),
    .out_inside_string        (out_inside_string),
    .out_inside_char_literal  (out_inside_char_literal)
  );

  always #5 clk = ~clk;

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 50) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic step_depth(input bit up);
    logic signed [DEPTH_BITS-1:0] top;
    logic signed [DEPTH_BITS-1:0] bottom;
    logic signed [DEPTH_BITS-1:0] one;
    top    = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    bottom = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    one    = {{(DEPTH_BITS-1){1'b0}}, 1'b1};
    if (up) begin
      if (brace_level < top) brace_level = brace_level + one;
    end else begin
      if (brace_level > bottom) brace_level = brace_level - one;
    end
  endtask

  // Character handling outside any comment.
  task automatic track_plain(input logic [7:0] c, input logic le);
    if (!lex_state.str_lit && !lex_state.chr_lit && c == CH_SLASH) begin
      if (!le) lex_state.slash_pend = 1'b1;
    end else if (c == CH_BACKSLASH) begin
      if (!le) lex_state.skip_next = 1'b1;
    end else begin
      if (!lex_state.chr_lit && c == CH_DQUOTE) lex_state.str_lit = ~lex_state.str_lit;
      else if (!lex_state.str_lit && c == CH_SQUOTE) lex_state.chr_lit = ~lex_state.chr_lit;
      if (!lex_state.str_lit && !lex_state.chr_lit) begin
        if (c == CH_LBRACE) step_depth(1'b1);
        else if (c == CH_RBRACE) step_depth(1'b0);
      end
    end
  endtask

  task automatic track_char(input logic [7:0] c, input logic le, input logic rs);
    logic signed [63:0] wide_level;
    lex_view_t view;
    if (rs) begin
      lex_state   = FLAGS_CLEAR;
      brace_level = '0;
    end
    if (lex_state.skip_next) begin
      lex_state.skip_next = 1'b0;
    end else if (lex_state.line_cmt) begin
      if (le) lex_state.line_cmt = 1'b0;
    end else if (lex_state.block_cmt) begin
      if (lex_state.star_pend && c == CH_SLASH) begin
        lex_state.block_cmt = 1'b0;
        lex_state.star_pend = 1'b0;
      end else begin
        lex_state.star_pend = (c == CH_STAR) && !le;
      end
    end else if (lex_state.slash_pend && c == CH_STAR) begin
      lex_state.slash_pend = 1'b0;
      lex_state.block_cmt  = 1'b1;
    end else if (lex_state.slash_pend && c == CH_SLASH) begin
      lex_state.slash_pend = 1'b0;
      if (!le) lex_state.line_cmt = 1'b1;
    end else begin
      lex_state.slash_pend = 1'b0;
      track_plain(c, le);
    end
    wide_level     = brace_level;
    view.depth     = wide_level[15:0];
    view.in_block  = lex_state.block_cmt;
    view.in_str    = lex_state.str_lit;
    view.in_chr    = lex_state.chr_lit;
    expected_views.push_back(view);
  endtask

  task automatic send_char(input logic [7:0] c, input logic le, input logic rs);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    in_line_end  <= le;
    in_restart   <= rs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_char(c, le, rs);
    chars_sent++;
  endtask

  // Random line ends and rare restarts on top of the text content.
  task automatic put_char(input logic [7:0] c, input logic force_end);
    send_char(c, force_end | ($urandom_range(11) == 0), $urandom_range(299) == 0);
  endtask

  function automatic logic [7:0] body_char();
    case ($urandom_range(9))
      0:       return CH_LBRACE;
      1:       return CH_RBRACE;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      4:       return CH_DQUOTE;
      5:       return CH_SQUOTE;
      6:       return CH_BACKSLASH;
      7:       return 8'h20;
      default: return 8'($urandom_range(8'h7A, 8'h61));
    endcase
  endfunction

  // Result side: random stalls, in-order compare against predictions.
  always @(posedge clk) begin
    lex_view_t want;
    if (rst_n && out_valid && out_ready) begin
      views_checked++;
      if (expected_views.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = expected_views.pop_front();
        if (out_brace_depth !== want.depth)
          report_mismatch($sformatf("beat %0d brace_depth got %0d exp %0d",
                                    views_checked, out_brace_depth, want.depth));
        if (out_inside_block_comment !== want.in_block)
          report_mismatch($sformatf("beat %0d inside_block_comment got %b exp %b",
                                    views_checked, out_inside_block_comment, want.in_block));
        if (out_inside_string !== want.in_str)
          report_mismatch($sformatf("beat %0d inside_string got %b exp %b",
                                    views_checked, out_inside_string, want.in_str));
        if (out_inside_char_literal !== want.in_chr)
          report_mismatch($sformatf("beat %0d inside_char_literal got %b exp %b",
                                    views_checked, out_inside_char_literal, want.in_chr));
      end
    end
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic set_idle(input int unsigned in_pct, input int unsigned out_pct);
    gap_pct   = in_pct;
    stall_pct = out_pct;
  endtask

  task automatic test_directed_cases();
    send_char(CH_LBRACE, 1'b0, 1'b1);
    send_char(CH_LBRACE, 1'b0, 1'b0);
    send_char(CH_RBRACE, 1'b0, 1'b0);
    // block comment opener split over two beats, star at line end is dropped
    send_char(CH_SLASH, 1'b0, 1'b0);
    send_char(CH_STAR, 1'b0, 1'b0);
    send_char(CH_LBRACE, 1'b0, 1'b0);
    send_char(CH_STAR, 1'b1, 1'b0);
    send_char(CH_SLASH, 1'b0, 1'b0);
    send_char(CH_STAR, 1'b0, 1'b0);
    send_char(CH_SLASH, 1'b0, 1'b0);
    // line comment runs to the line end
    send_char(CH_SLASH, 1'b0, 1'b0);
    send_char(CH_SLASH, 1'b0, 1'b0);
    send_char(CH_LBRACE, 1'b1, 1'b0);
    // escapes: skip next, no effect at line end
    send_char(CH_BACKSLASH, 1'b0, 1'b0);
    send_char(CH_LBRACE, 1'b0, 1'b0);
    send_char(CH_BACKSLASH, 1'b1, 1'b0);
    send_char(CH_LBRACE, 1'b0, 1'b0);
    // slash at line end, then slash followed by a plain brace
    send_char(CH_SLASH, 1'b1, 1'b0);
    send_char(CH_STAR, 1'b0, 1'b0);
    send_char(CH_SLASH, 1'b0, 1'b0);
    send_char(CH_RBRACE, 1'b0, 1'b0);
    // string hides braces and single quotes
    send_char(CH_DQUOTE, 1'b0, 1'b0);
    send_char(CH_RBRACE, 1'b0, 1'b0);
    send_char(CH_SQUOTE, 1'b0, 1'b0);
    send_char(CH_DQUOTE, 1'b0, 1'b0);
    // char literal hides slashes
    send_char(CH_SQUOTE, 1'b0, 1'b0);
    send_char(CH_SLASH, 1'b0, 1'b0);
    send_char(CH_SQUOTE, 1'b0, 1'b0);
    // byte extremes, and restart while inside a comment
    send_char(8'h00, 1'b0, 1'b0);
    send_char(CH_SLASH, 1'b0, 1'b0);
    send_char(CH_STAR, 1'b0, 1'b0);
    send_char(8'hFF, 1'b1, 1'b1);
  endtask

  task automatic test_depth_saturation();
    int unsigned n;
    // the limits are only reached in a short run when the counter is narrow
    if (DEPTH_BITS <= 6) n = (1 << (DEPTH_BITS - 1)) + 2;
    else n = 40;
    send_char(CH_LBRACE, 1'b0, 1'b1);
    repeat (n) send_char(CH_LBRACE, 1'b0, 1'b0);
    send_char(CH_RBRACE, 1'b0, 1'b0);
    send_char(CH_RBRACE, 1'b0, 1'b1);
    repeat (n) send_char(CH_RBRACE, 1'b0, 1'b0);
    send_char(CH_LBRACE, 1'b0, 1'b0);
    send_char(CH_SQUOTE, 1'b0, 1'b1);
  endtask

  task automatic test_random_text(input int unsigned n_chars);
    int unsigned stop_at;
    logic [7:0] c;
    stop_at = chars_sent + n_chars;
    while (chars_sent < stop_at) begin
      case ($urandom_range(11))
        0, 1: put_char(CH_LBRACE, 1'b0);
        2, 3: put_char(CH_RBRACE, 1'b0);
        4: begin
          put_char(CH_SLASH, 1'b0);
          put_char(CH_STAR, 1'b0);
          repeat ($urandom_range(6)) put_char(body_char(), 1'b0);
          put_char(CH_STAR, 1'b0);
          put_char(CH_SLASH, 1'b0);
        end
        5: begin
          put_char(CH_SLASH, 1'b0);
          put_char(CH_SLASH, 1'b0);
          repeat ($urandom_range(5)) put_char(body_char(), 1'b0);
          put_char(body_char(), 1'b1);
        end
        6: begin
          put_char(CH_DQUOTE, 1'b0);
          repeat ($urandom_range(6)) begin
            c = body_char();
            if (c == CH_DQUOTE || c == CH_BACKSLASH) put_char(CH_BACKSLASH, 1'b0);
            put_char(c, 1'b0);
          end
          put_char(CH_DQUOTE, 1'b0);
        end
        7: begin
          put_char(CH_SQUOTE, 1'b0);
          if ($urandom_range(2) == 0) put_char(CH_BACKSLASH, 1'b0);
          put_char(body_char(), 1'b0);
          put_char(CH_SQUOTE, 1'b0);
        end
        8:  repeat ($urandom_range(4, 1)) put_char(8'($urandom_range(8'h7A, 8'h61)), 1'b0);
        9:  repeat ($urandom_range(3, 1)) put_char(8'($urandom_range(255)), 1'b0);
        10: begin
          put_char(CH_SLASH, 1'b0);
          put_char(body_char(), 1'b0);
        end
        default: begin
          put_char(CH_BACKSLASH, 1'b0);
          put_char(8'($urandom_range(255)), 1'b0);
        end
      endcase
    end
  endtask

  task automatic finish_run();
    in_valid <= 1'b0;
    for (int i = 0; i < 1000 && expected_views.size() != 0; i++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (expected_views.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", expected_views.size()));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idle(0, 0);
    test_directed_cases();
    test_depth_saturation();
    test_random_text(235);
    set_idle(54, 0);
    test_random_text(235);
    set_idle(0, 54);
    test_random_text(235);
    set_idle(31, 31);
    test_random_text(235);
    set_idle(0, 0);
    finish_run();

    $display("Sent %0d characters, checked %0d result beats, %0d mismatches.",
             chars_sent, views_checked, mismatch_count);
    $display("Covered comments, literals, escapes, restarts, deep nesting, stall mixes.");
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
